// File: sv/serial_frame_deframer_sum16_defines.svh
// Assertion macros shared by the deframer modules.
`ifndef SERIAL_FRAME_DEFRAMER_SUM16_DEFINES_SVH
`define SERIAL_FRAME_DEFRAMER_SUM16_DEFINES_SVH

// Same-cycle implication, checked on clk outside reset.
`define SFD_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("deframer assertion failed");

// Next-cycle implication, checked on clk outside reset.
`define SFD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("deframer assertion failed");

`endif

// File: sv/sfd16_pkg.sv
// Shared types and constants of the serial frame deframer.
`timescale 1ns / 1ps
`default_nettype none

package sfd16_pkg;

	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	localparam logic [1:0] KIND_PAYLOAD = 2'd0;
	localparam logic [1:0] KIND_GOOD    = 2'd1;
	localparam logic [1:0] KIND_BAD     = 2'd2;

	localparam logic CFG_HEADER_FIRST  = 1'b0;
	localparam logic CFG_HEADER_SECOND = 1'b1;

	localparam logic [7:0] HEADER_FIRST_RST  = 8'd165;
	localparam logic [7:0] HEADER_SECOND_RST = 8'd168;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  data_byte;
		logic [7:0]  function_code;
		logic [15:0] payload_index;
		logic [15:0] frame_length;
		logic        last;
	} res_t;

endpackage

`default_nettype wire

// File: sv/serial_frame_deframer_sum16.sv
// Top level of the serial frame deframer with 16-bit additive checksum.
`timescale 1ns / 1ps
`default_nettype none

// Takes one received byte per clock cycle while the result queue has room: the
// phase tracker and the running sum update in the cycle the byte is accepted.
// Payload bytes and the frame end result enter a four-entry result queue that
// drives the output channel directly, so a result appears in the cycle after
// its byte at the earliest. s_tready drops only while the queue holds four
// undelivered results. No clearing pass after reset.
module serial_frame_deframer_sum16
	import sfd16_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // rx_byte
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata,   // data_byte, function_code, payload_index, frame_length
	output logic [1:0]       m_tuser,   // kind
	output logic             m_tlast,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [7:0]  cfg_data
);

	logic push;
	logic q_full;
	res_t push_item;
	res_t out_item;

	sfd16_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_byte   (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	sfd16_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_item  (out_item)
	);

	assign m_tdata = {out_item.frame_length, out_item.payload_index,
		out_item.function_code, out_item.data_byte};
	assign m_tuser = out_item.kind;
	assign m_tlast = out_item.last;

endmodule

`default_nettype wire

// File: sv/sfd16_front.sv
// Front end: accepts bytes, tracks the frame phase and builds result items.
`timescale 1ns / 1ps
`default_nettype none

`include "serial_frame_deframer_sum16_defines.svh"

module sfd16_front
	import sfd16_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] in_byte,
	input  wire logic       cfg_we,
	input  wire logic       cfg_index,
	input  wire logic [7:0] cfg_data,
	input  wire logic       q_full,
	output logic            push,
	output res_t            push_item
);

	localparam logic [2:0] PH_HUNT1   = 3'd0;
	localparam logic [2:0] PH_HUNT2   = 3'd1;
	localparam logic [2:0] PH_CODE    = 3'd2;
	localparam logic [2:0] PH_LEN_LO  = 3'd3;
	localparam logic [2:0] PH_LEN_HI  = 3'd4;
	localparam logic [2:0] PH_PAYLOAD = 3'd5;
	localparam logic [2:0] PH_SUM_LO  = 3'd6;
	localparam logic [2:0] PH_SUM_HI  = 3'd7;

	logic [7:0]  hdr_first_q, hdr_second_q;
	logic [2:0]  phase_q, phase_d;
	logic [7:0]  code_q, code_d;
	logic [15:0] length_q, length_d;
	logic [15:0] count_q, count_d;
	logic [15:0] sum_q, sum_d;
	logic [7:0]  sum_lo_q, sum_lo_d;
	logic        acc;
	logic [15:0] sum_add;
	logic [15:0] count_inc;
	logic [15:0] got_sum;

	assign in_ready  = !q_full;
	assign acc       = in_valid && in_ready;
	assign sum_add   = sum_q + {8'd0, in_byte};
	assign count_inc = count_q + 16'd1;
	assign got_sum   = {in_byte, sum_lo_q};

	always_comb begin
		phase_d   = phase_q;
		code_d    = code_q;
		length_d  = length_q;
		count_d   = count_q;
		sum_d     = sum_q;
		sum_lo_d  = sum_lo_q;
		push      = 1'b0;
		push_item = '{kind: KIND_PAYLOAD, data_byte: in_byte, function_code: code_q,
			payload_index: count_q, frame_length: length_q, last: 1'b0};
		unique case (phase_q)
			PH_HUNT1: begin
				if (in_byte == hdr_first_q) begin
					sum_d   = {8'd0, in_byte};
					phase_d = PH_HUNT2;
				end
			end
			PH_HUNT2: begin
				if (in_byte == hdr_second_q) begin
					sum_d   = sum_add;
					phase_d = PH_CODE;
				end else if (in_byte == hdr_first_q) begin
					sum_d = {8'd0, in_byte};
				end else begin
					phase_d = PH_HUNT1;
				end
			end
			PH_CODE: begin
				code_d  = in_byte;
				sum_d   = sum_add;
				phase_d = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				length_d = {8'd0, in_byte};
				sum_d    = sum_add;
				phase_d  = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				length_d = {in_byte, length_q[7:0]};
				sum_d    = sum_add;
				count_d  = 16'd0;
				phase_d  = ({in_byte, length_q[7:0]} == 16'd0) ? PH_SUM_LO : PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				sum_d   = sum_add;
				push    = acc;
				count_d = count_inc;
				if (count_inc == length_q)
					phase_d = PH_SUM_LO;
			end
			PH_SUM_LO: begin
				sum_lo_d = in_byte;
				phase_d  = PH_SUM_HI;
			end
			PH_SUM_HI: begin
				push                    = acc;
				push_item.kind          = (got_sum == sum_q) ? KIND_GOOD : KIND_BAD;
				push_item.data_byte     = 8'd0;
				push_item.payload_index = 16'd0;
				push_item.last          = 1'b1;
				phase_d                 = PH_HUNT1;
			end
			default: phase_d = PH_HUNT1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT1;
			code_q   <= 8'd0;
			length_q <= 16'd0;
			count_q  <= 16'd0;
			sum_q    <= 16'd0;
			sum_lo_q <= 8'd0;
		end else if (acc) begin
			phase_q  <= phase_d;
			code_q   <= code_d;
			length_q <= length_d;
			count_q  <= count_d;
			sum_q    <= sum_d;
			sum_lo_q <= sum_lo_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_first_q  <= HEADER_FIRST_RST;
			hdr_second_q <= HEADER_SECOND_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_HEADER_FIRST:  hdr_first_q  <= cfg_data;
				CFG_HEADER_SECOND: hdr_second_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// payload count stays below the length while payload is expected
	`SFD_ASSERT_IMPL(a_count_in_range, phase_q == PH_PAYLOAD, count_q < length_q)

endmodule

`default_nettype wire

// File: sv/sfd16_queue.sv
// Result queue between the front end and the output channel.
`timescale 1ns / 1ps
`default_nettype none

`include "serial_frame_deframer_sum16_defines.svh"

module sfd16_queue
	import sfd16_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  res_t      push_item,
	output logic      full,
	output logic      out_valid,
	input  wire logic out_ready,
	output res_t      out_item
);

	res_t           mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCW-1:0] count_q;
	logic           pop;

	assign full      = (count_q == QCW'(QDEPTH));
	assign out_valid = (count_q != '0);
	assign out_item  = mem_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			if (push && !pop)
				count_q <= count_q + QCW'(1);
			else if (pop && !push)
				count_q <= count_q - QCW'(1);
		end
	end

	`SFD_ASSERT_IMPL(a_no_overflow, push, !full)
	`SFD_ASSERT_IMPL(a_count_bound, 1'b1, count_q <= QCW'(QDEPTH))
	`SFD_ASSERT_NEXT(a_count_grows, push && !pop, count_q == $past(count_q) + QCW'(1))

endmodule

`default_nettype wire

// File: bench/tb_serial_frame_deframer_sum16.sv
// Self-checking bench for the serial frame deframer: byte driver, frame predictor, result monitor.
`timescale 1ns / 1ps

module tb_serial_frame_deframer_sum16;
	import sfd16_pkg::*;

	localparam int QUIET_LIMIT = 4000;

	typedef enum logic [2:0] {
		HUNT_FIRST, HUNT_SECOND, GET_CODE, GET_LEN_LO,
		GET_LEN_HI, GET_PAYLOAD, GET_SUM_LO, GET_SUM_HI
	} deframe_phase_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;
	logic        cfg_we = 1'b0;
	logic        cfg_index = 1'b0;
	logic [7:0]  cfg_data = '0;

	// predictor state and header settings
	deframe_phase_t ph = HUNT_FIRST;
	logic [7:0]     hdr_first = HEADER_FIRST_RST;
	logic [7:0]     hdr_second = HEADER_SECOND_RST;
	logic [7:0]     code_reg = '0;
	logic [15:0]    len_reg = '0;
	logic [15:0]    byte_cnt = '0;
	logic [15:0]    frame_sum = '0;
	logic [7:0]     sum_lo = '0;

	logic [7:0] rx_pending[$];
	res_t       pending_results[$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int errors = 0;
	int quiet_cycles = 0;

	serial_frame_deframer_sum16 uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #6 clk = ~clk;

	function automatic void put_rx(input logic [7:0] v);
		rx_pending.insert(rx_pending.size(), v);
	endfunction

	function automatic void put_result(input res_t v);
		pending_results.insert(pending_results.size(), v);
	endfunction

	function automatic void deframe_byte(input logic [7:0] b);
		res_t r;
		r = '0;
		case (ph)
			HUNT_FIRST: begin
				if (b == hdr_first) begin
					frame_sum = {8'h00, b};
					ph = HUNT_SECOND;
				end
			end
			HUNT_SECOND: begin
				if (b == hdr_second) begin
					frame_sum = frame_sum + b;
					ph = GET_CODE;
				end else if (b == hdr_first) begin
					frame_sum = {8'h00, b};
				end else begin
					ph = HUNT_FIRST;
				end
			end
			GET_CODE: begin
				code_reg = b;
				frame_sum = frame_sum + b;
				ph = GET_LEN_LO;
			end
			GET_LEN_LO: begin
				len_reg = {8'h00, b};
				frame_sum = frame_sum + b;
				ph = GET_LEN_HI;
			end
			GET_LEN_HI: begin
				len_reg[15:8] = b;
				frame_sum = frame_sum + b;
				byte_cnt = '0;
				ph = (len_reg == 16'd0) ? GET_SUM_LO : GET_PAYLOAD;
			end
			GET_PAYLOAD: begin
				frame_sum = frame_sum + b;
				r.kind = KIND_PAYLOAD;
				r.data_byte = b;
				r.function_code = code_reg;
				r.payload_index = byte_cnt;
				r.frame_length = len_reg;
				r.last = 1'b0;
				put_result(r);
				byte_cnt = byte_cnt + 16'd1;
				if (byte_cnt == len_reg)
					ph = GET_SUM_LO;
			end
			GET_SUM_LO: begin
				sum_lo = b;
				ph = GET_SUM_HI;
			end
			GET_SUM_HI: begin
				r.kind = ({b, sum_lo} == frame_sum) ? KIND_GOOD : KIND_BAD;
				r.function_code = code_reg;
				r.frame_length = len_reg;
				r.last = 1'b1;
				put_result(r);
				ph = HUNT_FIRST;
			end
		endcase
	endfunction

	function automatic void check_field(input string name, input int exp_v, input int got_v);
		if (exp_v != got_v) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
			errors++;
		end
	endfunction

	// byte driver; prediction runs on every accepted item
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else begin
			if (s_tvalid && s_tready)
				deframe_byte(s_tdata);
			if (!s_tvalid || s_tready) begin
				if (rx_pending.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tdata <= rx_pending.pop_front();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// result monitor
	always @(posedge clk) begin
		res_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected item, expected none, got kind %0d data %0h", $time,
					m_tuser, m_tdata);
				errors++;
			end else begin
				e = pending_results.pop_front();
				check_field("kind", e.kind, m_tuser);
				check_field("data_byte", e.data_byte, m_tdata[7:0]);
				check_field("function_code", e.function_code, m_tdata[15:8]);
				check_field("payload_index", e.payload_index, m_tdata[31:16]);
				check_field("frame_length", e.frame_length, m_tdata[47:32]);
				check_field("last", e.last, m_tlast);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	task automatic wait_idle();
		while (rx_pending.size() != 0 || s_tvalid || pending_results.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_header(input logic idx, input logic [7:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_HEADER_FIRST)
			hdr_first = v;
		else
			hdr_second = v;
		@(negedge clk);
	endtask

	task automatic queue_frame(input logic [7:0] code, input int len, input bit bad,
		input bit lead);
		logic [15:0] chk;
		logic [7:0]  b;
		if (lead)
			put_rx(hdr_first);
		chk = hdr_first + hdr_second + code + len[7:0] + len[15:8];
		put_rx(hdr_first);
		put_rx(hdr_second);
		put_rx(code);
		put_rx(len[7:0]);
		put_rx(len[15:8]);
		for (int i = 0; i < len; i++) begin
			b = 8'($urandom);
			chk = chk + b;
			put_rx(b);
		end
		if (bad)
			chk = chk ^ 16'($urandom_range(1, 65535));
		put_rx(chk[7:0]);
		put_rx(chk[15:8]);
	endtask

	task automatic queue_traffic(input int n);
		int          start;
		int          r;
		int          len;
		logic [7:0]  b;
		start = rx_pending.size();
		while (rx_pending.size() - start < n) begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 8);
				queue_frame(8'($urandom), len, $urandom_range(0, 3) == 0, r < 8);
			end else if (r < 85) begin
				repeat ($urandom_range(1, 3)) begin
					do b = 8'($urandom); while (b == hdr_first);
					put_rx(b);
				end
			end else begin
				// header start followed by a byte that breaks it
				put_rx(hdr_first);
				do b = 8'($urandom); while (b == hdr_first || b == hdr_second);
				put_rx(b);
			end
		end
	endtask

	initial begin
		logic [7:0]  h1;
		logic [7:0]  h2;
		logic [15:0] chk;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty frame, extreme bytes, broken header, resync, bad checksum
		queue_frame(8'h00, 0, 1'b0, 1'b0);
		put_rx(8'hFF);
		put_rx(8'h00);
		put_rx(hdr_second);
		put_rx(hdr_first);
		put_rx(hdr_first);
		put_rx(hdr_second);
		put_rx(8'hFF);
		put_rx(8'h02);
		put_rx(8'h00);
		put_rx(8'h00);
		put_rx(8'hFF);
		chk = hdr_first + hdr_second + 16'h00FF + 16'h0002 + 16'h00FF;
		put_rx(chk[7:0]);
		put_rx(chk[15:8]);
		put_rx(hdr_first);
		put_rx(8'h00);
		queue_frame(8'h81, 0, 1'b1, 1'b1);
		wait_idle();

		// header change in the middle of a frame
		h1 = hdr_first;
		h2 = hdr_second;
		put_rx(h1);
		put_rx(h2);
		put_rx(8'h3C);
		put_rx(8'h03);
		put_rx(8'h00);
		put_rx(8'h10);
		wait_idle();
		write_header(CFG_HEADER_FIRST, 8'h11);
		chk = h1 + h2 + 16'h003C + 16'h0003 + 16'h0010 + 16'h0020 + 16'h0030;
		put_rx(8'h20);
		put_rx(8'h30);
		put_rx(chk[7:0]);
		put_rx(chk[15:8]);
		queue_frame(8'h42, 1, 1'b0, 1'b0);
		wait_idle();

		for (int s = 0; s < 5; s++) begin
			case (s)
				0: begin h1 = HEADER_FIRST_RST; h2 = HEADER_SECOND_RST; end
				1: begin h1 = 8'h00; h2 = 8'hFF; end
				2: begin h1 = 8'hFF; h2 = 8'h00; end
				3: begin h1 = 8'h5A; h2 = 8'h5A; end
				default: begin h1 = 8'($urandom); h2 = 8'($urandom); end
			endcase
			write_header(CFG_HEADER_FIRST, h1);
			write_header(CFG_HEADER_SECOND, h2);
			case (s % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 57; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 57; end
				default: begin send_idle_pct = 22; recv_stall_pct = 22; end
			endcase
			queue_traffic(40);
			// sender holds off until every result is back
			wait_idle();
			queue_traffic(40);
			wait_idle();
		end

		repeat (20) @(negedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
